### sv/lus_pkg.sv
package lus_pkg;

  // Default alphabet size and the fixed field widths.
  localparam int AlphabetSizeDef = 26;
  localparam int LetterW         = 5;
  localparam int LenW            = 5;

  // Letter reported with the single result of an empty string.
  localparam logic [LetterW-1:0] EmptyLetter = '0;

  // Controls that are broadcast along the row of window cells.
  typedef struct packed {
    logic clear;  // empty the window
    logic shift;  // drop the oldest letter, all cells move one place down
  } win_ctl_t;

  // Controls that are broadcast along the row of best-substring cells.
  typedef struct packed {
    logic load;   // copy the window as the new best substring
    logic shift;  // move one place down while the result is read out
  } best_ctl_t;

endpackage

### sv/lus_if.sv
interface lus_in_if;
  import lus_pkg::*;

  logic               valid;
  logic               ready;
  logic [LetterW-1:0] letter;
  logic               end_of_string;

  modport source (output valid, output letter, output end_of_string, input ready);
  modport sink   (input valid, input letter, input end_of_string, output ready);
endinterface

interface lus_out_if;
  import lus_pkg::*;

  logic               valid;
  logic               ready;
  logic [LenW-1:0]    best_length;
  logic [LetterW-1:0] out_letter;
  logic               is_empty;
  logic               last_of_run;

  modport source (output valid, output best_length, output out_letter,
                  output is_empty, output last_of_run, input ready);
  modport sink   (input valid, input best_length, input out_letter,
                  input is_empty, input last_of_run, output ready);
endinterface

### sv/longest_unique_substring.sv
// Channel | Dir | Payload                                          | Handshake
// in_i    | in  | letter[4:0], end_of_string                       | valid/ready
// out_o   | out | best_length[4:0], out_letter[4:0], is_empty,     | valid/ready
//         |     | last_of_run                                      |
//
// A letter that is not yet in the window is appended as it is taken. A repeated
// letter starts a shrink in which the window row of cells drops one letter per
// cycle, the repeat included; the new letter then takes the freed top slot.
// On the end mark the best substring leaves at one result per cycle while the output
// is ready, one result for an empty string; all state is cleared with the last result.
// Input is taken only while no letter is being processed and no result waits;
// a stalled output holds its result. Reset is asynchronous, active low.
module longest_unique_substring #(
  parameter int AlphabetSize = lus_pkg::AlphabetSizeDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  lus_in_if.sink    in_i,
  lus_out_if.source out_o
);
  import lus_pkg::*;

  localparam int SizeW = $clog2(AlphabetSize + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StShrink = 2'd1;
  localparam logic [1:0] StOut    = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic [SizeW-1:0]   best_q, best_d;
  logic [SizeW-1:0]   idx_q, idx_d;
  logic [LetterW-1:0] code_q, code_d;
  logic               last_q, last_d;

  logic [LetterW-1:0] code;
  logic               in_acc, out_acc, in_range, any_match, popped_hit;
  logic               append_en;
  logic [SizeW-1:0]   app_idx;
  win_ctl_t           win_ctl;
  best_ctl_t          best_ctl;

  logic [AlphabetSize-1:0]              win_valid, win_match, append_here;
  logic [AlphabetSize-1:0][LetterW-1:0] win_letter, best_letter;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign code     = (state_q == StIdle) ? in_i.letter : code_q;
  assign in_range = 32'(in_i.letter) < AlphabetSize;
  assign any_match  = |win_match;
  assign popped_hit = win_letter[0] == code_q;

  // Sequencer: append, shrink one letter per cycle, then read out.
  always_comb begin
    state_d   = state_q;
    size_d    = size_q;
    best_d    = best_q;
    idx_d     = idx_q;
    code_d    = code_q;
    last_d    = last_q;
    append_en = 1'b0;
    app_idx   = size_q;
    win_ctl   = '0;
    best_ctl  = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          code_d = in_i.letter;
          last_d = in_i.end_of_string;
          if (in_range && any_match) begin
            state_d = StShrink;
          end else begin
            if (in_range && (32'(size_q) < AlphabetSize)) begin
              append_en = 1'b1;
              size_d    = size_q + SizeW'(1);
              if (size_d > best_q) begin
                best_d        = size_d;
                best_ctl.load = 1'b1;
              end
            end
            state_d = in_i.end_of_string ? StOut : StIdle;
          end
        end
      end
      StShrink: begin
        win_ctl.shift = 1'b1;
        if (popped_hit) begin
          // The repeat is gone: the new letter takes the freed top slot.
          append_en = 1'b1;
          app_idx   = size_q - SizeW'(1);
          state_d   = last_q ? StOut : StIdle;
        end else begin
          size_d = size_q - SizeW'(1);
        end
      end
      StOut: begin
        if (out_acc) begin
          if (out_o.last_of_run) begin
            win_ctl.clear = 1'b1;
            size_d        = '0;
            best_d        = '0;
            idx_d         = '0;
            state_d       = StIdle;
          end else begin
            best_ctl.shift = 1'b1;
            idx_d          = idx_q + SizeW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      size_q  <= '0;
      best_q  <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      best_q  <= best_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  // Row of window cells, oldest letter in cell zero, with a best copy beside.
  for (genvar k = 0; k < AlphabetSize; k++) begin : g_cell
    logic [LetterW-1:0] next_letter, next_best, src_letter;
    logic               next_valid;

    assign append_here[k] = append_en && (app_idx == SizeW'(k));
    assign src_letter     = append_here[k] ? code : win_letter[k];

    if (k == AlphabetSize - 1) begin : g_end
      assign next_letter = '0;
      assign next_valid  = 1'b0;
      assign next_best   = '0;
    end else begin : g_mid
      assign next_letter = win_letter[k+1];
      assign next_valid  = win_valid[k+1];
      assign next_best   = best_letter[k+1];
    end

    lus_win_cell u_win (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (win_ctl),
      .append_i      (append_here[k]),
      .code_i        (code),
      .next_letter_i (next_letter),
      .next_valid_i  (next_valid),
      .letter_o      (win_letter[k]),
      .valid_o       (win_valid[k]),
      .match_o       (win_match[k])
    );

    lus_best_cell u_best (
      .clk_i         (clk_i),
      .ctl_i         (best_ctl),
      .src_letter_i  (src_letter),
      .next_letter_i (next_best),
      .letter_o      (best_letter[k])
    );
  end

  // Handshake and result fields.
  assign in_i.ready        = state_q == StIdle;
  assign out_o.valid       = state_q == StOut;
  assign out_o.is_empty    = best_q == '0;
  assign out_o.best_length = LenW'(32'(best_q));
  assign out_o.out_letter  = (best_q == '0) ? EmptyLetter : best_letter[0];
  assign out_o.last_of_run = (best_q == '0) || (idx_q == best_q - SizeW'(1));

  // The window never outgrows the best substring kept so far.
  assert property (@(posedge clk_i) disable iff (!rst_ni) size_q <= best_q)
    else $error("window longer than best substring");

  // Shrinking only runs while the pending letter is still in the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StShrink |-> any_match && size_q != '0)
    else $error("shrink without a repeated letter");

  // The final result clears all state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_o.last_of_run |=> state_q == StIdle && best_q == '0 && win_valid == '0)
    else $error("state not cleared after the last result");

  // The number of valid window cells equals the window size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(win_valid) == 32'(size_q))
    else $error("window cell count differs from window size");

endmodule

### sv/lus_win_cell.sv
module lus_win_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lus_pkg::win_ctl_t           ctl_i,
  input  logic                        append_i,
  input  logic [lus_pkg::LetterW-1:0] code_i,
  input  logic [lus_pkg::LetterW-1:0] next_letter_i,
  input  logic                        next_valid_i,
  output logic [lus_pkg::LetterW-1:0] letter_o,
  output logic                        valid_o,
  output logic                        match_o
);
  import lus_pkg::*;

  logic [LetterW-1:0] letter_q, letter_d;
  logic               valid_q, valid_d;

  // A clear empties the cell; else the cell takes the new letter when it is the append
  // slot, else the neighbor's letter while the window drops its oldest entry.
  always_comb begin
    letter_d = letter_q;
    valid_d  = valid_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (append_i) begin
      letter_d = code_i;
      valid_d  = 1'b1;
    end else if (ctl_i.shift) begin
      letter_d = next_letter_i;
      valid_d  = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
  end

  // A held letter equal to the incoming code means it repeats.
  assign match_o  = valid_q && (letter_q == code_i);
  assign letter_o = letter_q;
  assign valid_o  = valid_q;

endmodule

### sv/lus_best_cell.sv
module lus_best_cell (
  input  logic                        clk_i,
  input  lus_pkg::best_ctl_t          ctl_i,
  input  logic [lus_pkg::LetterW-1:0] src_letter_i,
  input  logic [lus_pkg::LetterW-1:0] next_letter_i,
  output logic [lus_pkg::LetterW-1:0] letter_o
);
  import lus_pkg::*;

  logic [LetterW-1:0] letter_q, letter_d;

  // Load from the window on a new best, move down while reading out.
  always_comb begin
    letter_d = letter_q;
    if (ctl_i.load) begin
      letter_d = src_letter_i;
    end else if (ctl_i.shift) begin
      letter_d = next_letter_i;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
  end

  assign letter_o = letter_q;

endmodule

### dv/tb_longest_unique_substring.sv
module tb_longest_unique_substring;
  timeunit 1ns;
  timeprecision 1ps;

  import lus_pkg::*;

  localparam int AlphaN      = AlphabetSizeDef;
  localparam int ItemTarget  = 500;
  localparam int QuietLimit  = 5000;
  localparam int DrainCycles = 40;

  // Traffic phases, cycled through as requests are taken.
  typedef enum logic [1:0] {
    PhaseSteady,
    PhaseSenderGaps,
    PhaseReceiverStalls,
    PhaseBothIdle
  } traffic_phase_e;

  // Kinds of random strings.
  typedef enum logic [2:0] {
    StrNarrow,
    StrWide,
    StrPermutation,
    StrNoisy,
    StrAllNoise
  } string_kind_e;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               end_of_string;
  } letter_req_t;

  typedef struct packed {
    logic [LenW-1:0]    best_length;
    logic [LetterW-1:0] out_letter;
    logic               is_empty;
    logic               last_of_run;
  } run_result_t;

  logic clk_i;
  logic rst_ni;

  lus_in_if  letter_bus ();
  lus_out_if run_bus ();

  longest_unique_substring #(
    .AlphabetSize(AlphaN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (letter_bus),
    .out_o (run_bus)
  );

  letter_req_t pending_letters[$];
  run_result_t expected_runs[$];
  letter_req_t next_req;
  run_result_t seen_run;
  run_result_t want_run;

  int unsigned    requests_taken;
  int unsigned    total_requests;
  int unsigned    error_count;
  int unsigned    quiet_cycles;
  bit             timed_out;
  traffic_phase_e phase;

  // Window tracker state.
  logic [1:0]         letter_tally[AlphaN];
  logic [LetterW-1:0] win_ring[AlphaN];
  int unsigned        win_head;
  int unsigned        win_len;
  int unsigned        best_len;
  logic [LetterW-1:0] best_run[AlphaN];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clear the window tracker, as after reset or after a string ends.
  task automatic clear_window();
    for (int i = 0; i < AlphaN; i++) begin
      letter_tally[i] = '0;
      win_ring[i]     = '0;
      best_run[i]     = '0;
    end
    win_head = 0;
    win_len  = 0;
    best_len = 0;
  endtask

  // Feed one accepted letter to the tracker and queue the results it causes.
  task automatic absorb_letter(input logic [LetterW-1:0] code, input logic last);
    logic [LetterW-1:0] oldest;
    run_result_t        res;
    if (int'(code) < AlphaN) begin
      // Drop the oldest letters until the new one is no longer in the window.
      while (win_len > 0 && letter_tally[code] > 0) begin
        oldest = win_ring[win_head];
        if (letter_tally[oldest] > 0) letter_tally[oldest]--;
        win_head = (win_head + 1) % AlphaN;
        win_len--;
      end
      if (win_len < AlphaN) begin
        win_ring[(win_head + win_len) % AlphaN] = code;
        win_len++;
        letter_tally[code]++;
      end
      // A strictly longer window replaces the best one.
      if (win_len > best_len) begin
        best_len = win_len;
        for (int i = 0; i < AlphaN; i++) begin
          if (i < win_len) best_run[i] = win_ring[(win_head + i) % AlphaN];
        end
      end
    end
    if (last) begin
      if (best_len == 0) begin
        res.best_length = '0;
        res.out_letter  = EmptyLetter;
        res.is_empty    = 1'b1;
        res.last_of_run = 1'b1;
        expected_runs.push_back(res);
      end else begin
        for (int i = 0; i < AlphaN; i++) begin
          if (i < best_len) begin
            res.best_length = LenW'(best_len);
            res.out_letter  = best_run[i];
            res.is_empty    = 1'b0;
            res.last_of_run = (i + 1 == best_len);
            expected_runs.push_back(res);
          end
        end
      end
      clear_window();
    end
  endtask

  task automatic queue_letter(input int code, input bit last);
    letter_req_t req;
    req.letter        = LetterW'(code);
    req.end_of_string = last;
    pending_letters.push_back(req);
  endtask

  // Build one random string; its final letter carries the end mark.
  task automatic queue_string(input string_kind_e kind);
    int perm[AlphaN];
    int span;
    int count;
    int pick;
    int tmp;
    case (kind)
      StrNarrow: begin
        span  = $urandom_range(2, 8);
        count = $urandom_range(1, 30);
        for (int i = 0; i < count; i++) begin
          queue_letter($urandom_range(0, span - 1), i == count - 1);
        end
      end
      StrWide: begin
        count = $urandom_range(1, 60);
        for (int i = 0; i < count; i++) begin
          queue_letter($urandom_range(0, AlphaN - 1), i == count - 1);
        end
      end
      StrPermutation: begin
        for (int i = 0; i < AlphaN; i++) perm[i] = i;
        for (int i = AlphaN - 1; i > 0; i--) begin
          pick       = $urandom_range(0, i);
          tmp        = perm[i];
          perm[i]    = perm[pick];
          perm[pick] = tmp;
        end
        // A few repeated letters in front, then every letter once.
        count = $urandom_range(0, 4);
        for (int i = 0; i < count; i++) queue_letter($urandom_range(0, 3), 1'b0);
        for (int i = 0; i < AlphaN; i++) queue_letter(perm[i], i == AlphaN - 1);
      end
      StrNoisy: begin
        count = $urandom_range(1, 40);
        for (int i = 0; i < count; i++) begin
          if ($urandom_range(0, 99) < 30) begin
            queue_letter($urandom_range(AlphaN, 31), i == count - 1);
          end else begin
            queue_letter($urandom_range(0, AlphaN - 1), i == count - 1);
          end
        end
      end
      default: begin
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++) begin
          queue_letter($urandom_range(AlphaN, 31), i == count - 1);
        end
      end
    endcase
  endtask

  function automatic int sender_idle_pct(input traffic_phase_e ph);
    case (ph)
      PhaseSenderGaps: return 46;
      PhaseBothIdle:   return 11;
      default:         return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input traffic_phase_e ph);
    case (ph)
      PhaseReceiverStalls: return 46;
      PhaseBothIdle:       return 11;
      default:             return 0;
    endcase
  endfunction

  assign phase = traffic_phase_e'((requests_taken / 60) % 4);

  // Request driver: take accepted letters into the tracker, then offer the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_bus.valid         <= 1'b0;
      letter_bus.letter        <= '0;
      letter_bus.end_of_string <= 1'b0;
    end else begin
      if (letter_bus.valid && letter_bus.ready) begin
        absorb_letter(letter_bus.letter, letter_bus.end_of_string);
        requests_taken <= requests_taken + 1;
      end
      if (!letter_bus.valid || letter_bus.ready) begin
        if (pending_letters.size() > 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(phase)) begin
          next_req = pending_letters.pop_front();
          letter_bus.valid         <= 1'b1;
          letter_bus.letter        <= next_req.letter;
          letter_bus.end_of_string <= next_req.end_of_string;
        end else begin
          letter_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_bus.ready <= 1'b0;
    end else begin
      if (run_bus.valid && run_bus.ready) begin
        seen_run.best_length = run_bus.best_length;
        seen_run.out_letter  = run_bus.out_letter;
        seen_run.is_empty    = run_bus.is_empty;
        seen_run.last_of_run = run_bus.last_of_run;
        if (expected_runs.size() == 0) begin
          $display("%0t: unexpected result len=%0d letter=%0d empty=%0b last=%0b",
                   $time, seen_run.best_length, seen_run.out_letter,
                   seen_run.is_empty, seen_run.last_of_run);
          error_count++;
        end else begin
          want_run = expected_runs.pop_front();
          if (seen_run.best_length !== want_run.best_length ||
              seen_run.out_letter  !== want_run.out_letter  ||
              seen_run.is_empty    !== want_run.is_empty    ||
              seen_run.last_of_run !== want_run.last_of_run) begin
            $display("%0t: mismatch expected len=%0d letter=%0d empty=%0b last=%0b",
                     $time, want_run.best_length, want_run.out_letter,
                     want_run.is_empty, want_run.last_of_run);
            $display("%0t:          actual   len=%0d letter=%0d empty=%0b last=%0b",
                     $time, seen_run.best_length, seen_run.out_letter,
                     seen_run.is_empty, seen_run.last_of_run);
            error_count++;
          end
        end
      end
      run_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct(phase));
    end
  end

  // Count cycles in which neither side moves anything.
  always @(posedge clk_i) begin
    if (!rst_ni || (letter_bus.valid && letter_bus.ready) ||
        (run_bus.valid && run_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    letter_bus.valid         = 1'b0;
    letter_bus.letter        = '0;
    letter_bus.end_of_string = 1'b0;
    run_bus.ready            = 1'b0;
    rst_ni         = 1'b0;
    requests_taken = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    timed_out      = 1'b0;
    clear_window();

    // Directed strings: empty string, single letter, end mark on an ignored
    // letter, a repeat in the middle, a tie that keeps the earlier run, and
    // ignored letters mixed in.
    queue_letter(31, 1'b1);
    queue_letter(0, 1'b1);
    queue_letter(25, 1'b0);
    queue_letter(25, 1'b0);
    queue_letter(26, 1'b1);
    queue_letter(0, 1'b0);
    queue_letter(1, 1'b0);
    queue_letter(2, 1'b0);
    queue_letter(0, 1'b0);
    queue_letter(3, 1'b1);
    queue_letter(0, 1'b0);
    queue_letter(1, 1'b0);
    queue_letter(1, 1'b0);
    queue_letter(0, 1'b1);
    queue_letter(28, 1'b0);
    queue_letter(2, 1'b0);
    queue_letter(27, 1'b1);

    // Random strings, mostly well formed with some noise.
    while (pending_letters.size() < ItemTarget) begin
      case ($urandom_range(0, 99)) inside
        [0:54]:  queue_string(StrNarrow);
        [55:74]: queue_string(StrWide);
        [75:84]: queue_string(StrPermutation);
        [85:94]: queue_string(StrNoisy);
        default: queue_string(StrAllNoise);
      endcase
    end
    total_requests = pending_letters.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        while (requests_taken != total_requests || expected_runs.size() != 0) begin
          @(posedge clk_i);
        end
        repeat (DrainCycles) @(posedge clk_i);
      end
      begin
        while (quiet_cycles < QuietLimit) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
